/* rtl/sms_pkg.sv */
package sms_pkg;

  localparam int unsigned DIM_MAX = 8;
  localparam int unsigned DEPTH   = DIM_MAX * DIM_MAX;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned IDX_W   = 3;

  // Register indexes of the configuration port
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // Clamped matrix dimensions handed to the sequencer
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [CNT_W-1:0] total;
  } dim_t;

  typedef enum logic [7:0] {
    ST_LOAD   = 8'b0000_0001,
    ST_KEY    = 8'b0000_0010,
    ST_KEYW   = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_DRAIN  = 8'b0001_0000,
    ST_EMRD   = 8'b0010_0000,
    ST_EMLD   = 8'b0100_0000,
    ST_EMWAIT = 8'b1000_0000
  } state_e;

endpackage

/* rtl/sms_ram.sv */
module sms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/sms_cmp.sv */
module sms_cmp (
  input  logic signed [sms_pkg::DATA_W-1:0] cand_i,
  input  logic [sms_pkg::ADDR_W-1:0]        cand_idx_i,
  input  logic signed [sms_pkg::DATA_W-1:0] key_i,
  input  logic [sms_pkg::ADDR_W-1:0]        key_idx_i,
  output logic                              less_o
);
  import sms_pkg::*;

  // Strict order: equal values break ties on store index, so ranks form a permutation
  assign less_o = (cand_i < key_i) || ((cand_i == key_i) && (cand_idx_i < key_idx_i));

endmodule

/* rtl/sms_seq.sv */
module sms_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sms_pkg::dim_t                     dim_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sms_pkg::DATA_W-1:0] element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sms_pkg::IDX_W-1:0]         out_row_o,
  output logic [sms_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [sms_pkg::DATA_W-1:0] out_value_o,
  output logic                              run_last_o
);
  import sms_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [ADDR_W-1:0]   i_q, i_d;
  logic [ADDR_W-1:0]   j_q, j_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [DATA_W-1:0]   key_q, key_d;
  logic [ADDR_W-1:0]   rank_q, rank_d;
  logic [IDX_W-1:0]    r_q, r_d;
  logic [IDX_W-1:0]    c_q, c_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_row_q, out_row_d;
  logic [IDX_W-1:0]    out_col_q, out_col_d;
  logic [DATA_W-1:0]   out_value_q, out_value_d;
  logic                out_last_q, out_last_d;

  logic                in_fire;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    n_m1;
  logic                less;
  logic [ADDR_W-1:0]   rank_fin;
  logic [DATA_W-1:0]   elem_rdata;
  logic [DATA_W-1:0]   sort_rdata;
  logic [ADDR_W-1:0]   elem_raddr;
  logic [IDX_W-1:0]    col_last;
  logic [IDX_W-1:0]    row_last;
  logic [IDX_W-1:0]    col_off;
  logic [ADDR_W-1:0]   src_addr;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cnt_inc    = load_cnt_q + CNT_W'(1);
  assign n_m1       = n_q - CNT_W'(1);
  assign rank_fin   = rank_q + ADDR_W'(less);
  assign elem_raddr = (state_q == ST_KEY) ? i_q : j_q;

  assign col_last = IDX_W'(dim_i.cols - DIM_W'(1));
  assign row_last = IDX_W'(dim_i.rows - DIM_W'(1));
  // Odd rows run right to left
  assign col_off  = r_q[0] ? (col_last - c_q) : c_q;
  assign src_addr = base_q + ADDR_W'(col_off);

  sms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (load_cnt_q[ADDR_W-1:0]),
    .wdata_i (element_value_i),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  sms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_DRAIN),
    .waddr_i (rank_fin),
    .wdata_i (key_q),
    .raddr_i (src_addr),
    .rdata_o (sort_rdata)
  );

  sms_cmp u_cmp (
    .cand_i     (elem_rdata),
    .cand_idx_i (cmp_idx_q),
    .key_i      (key_q),
    .key_idx_i  (i_q),
    .less_o     (less)
  );

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    key_d       = key_q;
    rank_d      = rank_q;
    r_d         = r_q;
    c_d         = c_q;
    base_d      = base_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_inc >= dim_i.total) begin
            load_cnt_d = '0;
            n_d        = dim_i.total;
            i_d        = '0;
            state_d    = ST_KEY;
          end else begin
            load_cnt_d = cnt_inc;
          end
        end
      end
      ST_KEY: begin
        state_d = ST_KEYW;
      end
      ST_KEYW: begin
        key_d     = elem_rdata;
        j_d       = '0;
        rank_d    = '0;
        cmp_vld_d = 1'b0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = j_q;
        if (cmp_vld_q) begin
          rank_d = rank_fin;
        end
        if (CNT_W'(j_q) == n_m1) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        cmp_vld_d = 1'b0;
        if (CNT_W'(i_q) == n_m1) begin
          r_d     = '0;
          c_d     = '0;
          base_d  = '0;
          state_d = ST_EMRD;
        end else begin
          i_d     = i_q + ADDR_W'(1);
          state_d = ST_KEY;
        end
      end
      ST_EMRD: begin
        state_d = ST_EMLD;
      end
      ST_EMLD: begin
        out_valid_d = 1'b1;
        out_row_d   = r_q;
        out_col_d   = c_q;
        out_value_d = sort_rdata;
        out_last_d  = (r_q == row_last) && (c_q == col_last);
        state_d     = ST_EMWAIT;
      end
      ST_EMWAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_LOAD;
          end else begin
            if (c_q == col_last) begin
              c_d    = '0;
              r_d    = r_q + IDX_W'(1);
              base_d = base_q + ADDR_W'(dim_i.cols);
            end else begin
              c_d = c_q + IDX_W'(1);
            end
            state_d = ST_EMRD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cmp_vld_q   <= 1'b0;
      rank_q      <= '0;
      r_q         <= '0;
      c_q         <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cmp_vld_q   <= cmp_vld_d;
      rank_q      <= rank_d;
      r_q         <= r_d;
      c_q         <= c_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    key_q       <= key_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign run_last_o  = out_last_q;

endmodule

/* rtl/sort_matrix_snake_order.sv */
// Channel   Direction  Handshake                 Word
// -------   ---------  ------------------------  ----------------------------------------
// input     in         in_valid_i / in_ready_o   element_value_i
// output    out        out_valid_o / out_ready_i out_row_o, out_col_o, out_value_o,
//                                                run_last_o
// config    in         APB psel/penable/pwrite   row_count @ 0x0, col_count @ 0x4
//
// Loading accepts a word whenever in_valid_i and in_ready_o are high; n = rows*cols words
// make one matrix. After the last word the block sorts: each element is ranked by one
// shared comparator that walks the element RAM once, then written to its rank in the
// sorted RAM. Emission then handles one result at a time and waits out any output stall:
// each result is a sorted-RAM read followed by the output register.
// Reset clears control state only; both RAMs hold garbage until written. in_ready_o is
// low from the last word of a matrix until its last result is taken.
module sort_matrix_snake_order (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sms_pkg::DATA_W-1:0] element_value_i,
  // Output words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sms_pkg::IDX_W-1:0]         out_row_o,
  output logic [sms_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [sms_pkg::DATA_W-1:0] out_value_o,
  output logic                              run_last_o
);
  import sms_pkg::*;

  logic [DIM_W-1:0] row_count_q;
  logic [DIM_W-1:0] col_count_q;
  logic             cfg_wr;
  logic             reg_sel;
  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [2*DIM_W-1:0] total_full;
  dim_t             dim;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Hold raw register values; clamp on the way out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= DIM_W'(5);
      col_count_q <= DIM_W'(4);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROW_COUNT: row_count_q <= pwdata[DIM_W-1:0];
        REG_COL_COUNT: col_count_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROW_COUNT: prdata = 32'(row_count_q);
      REG_COL_COUNT: prdata = 32'(col_count_q);
      default:       prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the maximum as the maximum
  assign rows_eff = (row_count_q == '0) ? DIM_W'(1) :
                    (row_count_q > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : row_count_q;
  assign cols_eff = (col_count_q == '0) ? DIM_W'(1) :
                    (col_count_q > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : col_count_q;

  assign total_full = rows_eff * cols_eff;

  assign dim.rows  = rows_eff;
  assign dim.cols  = cols_eff;
  assign dim.total = total_full[CNT_W-1:0];

  sms_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dim_i           (dim),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .out_value_o     (out_value_o),
    .run_last_o      (run_last_o)
  );

endmodule

/* sim/snake_sort_checker.sv */
`timescale 1ns / 1ps

module snake_sort_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [2:0]                        paddr_i,
  input  logic [31:0]                       pwdata_i,
  input  logic                              pready_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [sms_pkg::DATA_W-1:0] element_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [sms_pkg::IDX_W-1:0]         out_row_i,
  input  logic [sms_pkg::IDX_W-1:0]         out_col_i,
  input  logic signed [sms_pkg::DATA_W-1:0] out_value_i,
  input  logic                              run_last_i,
  output int                                mismatch_count_o,
  output int                                pending_count_o
);
  import sms_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
  } position_t;

  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;
  logic [CNT_W-1:0]         words_loaded;
  logic signed [DATA_W-1:0] matrix_mem [DEPTH];
  position_t                placed_q [$];

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > DIM_MAX) return DIM_MAX;
    return raw;
  endfunction

  task automatic report(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int unsigned rows, cols, total, src, n;
    int j;
    logic signed [DATA_W-1:0] ranked [DEPTH];
    logic signed [DATA_W-1:0] key;
    position_t got, want;
    if (!rst_ni) begin
      rows_reg         = 4'd5;
      cols_reg         = 4'd4;
      words_loaded     = '0;
      placed_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == {REG_ROW_COUNT, 2'b00}) rows_reg = pwdata_i[DIM_W-1:0];
        else if (paddr_i == {REG_COL_COUNT, 2'b00}) cols_reg = pwdata_i[DIM_W-1:0];
      end

      if (out_valid_i && out_ready_i) begin
        got = '{out_row_i, out_col_i, out_value_i, run_last_i};
        if (placed_q.size() == 0) begin
          report($sformatf("unexpected word: row %0d col %0d value %0d last %0b",
                           got.row, got.col, $signed(got.value), got.last));
        end else begin
          want = placed_q.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.value !== want.value || got.last !== want.last)
            report($sformatf({"word mismatch: row %0d/%0d col %0d/%0d ",
                              "value %0d/%0d last %0b/%0b (expected/actual)"},
                             want.row, got.row, want.col, got.col,
                             $signed(want.value), $signed(got.value),
                             want.last, got.last));
        end
      end

      if (in_valid_i && in_ready_i) begin
        rows  = clamp_dim(rows_reg);
        cols  = clamp_dim(cols_reg);
        total = rows * cols;
        if (words_loaded < DEPTH) matrix_mem[words_loaded] = element_value_i;
        words_loaded = words_loaded + 1'b1;
        if (words_loaded >= total) begin
          // rank the first total words of this load, ascending signed
          for (int unsigned k = 0; k < total; k++) ranked[k] = matrix_mem[k];
          for (int i = 1; i < int'(total); i++) begin
            key = ranked[i];
            j   = i;
            while (j > 0 && key < ranked[j-1]) begin
              ranked[j] = ranked[j-1];
              j--;
            end
            ranked[j] = key;
          end
          // odd rows take their run of values right to left
          n = 0;
          for (int unsigned r = 0; r < rows; r++) begin
            for (int unsigned c = 0; c < cols; c++) begin
              src        = (r % 2 == 1) ? r * cols + (cols - 1 - c) : r * cols + c;
              want.row   = IDX_W'(r);
              want.col   = IDX_W'(c);
              want.value = ranked[src];
              want.last  = (n + 1 == total);
              placed_q.push_back(want);
              n++;
            end
          end
          words_loaded = '0;
        end
      end
    end
    pending_count_o = placed_q.size();
  end

endmodule

/* sim/sort_matrix_snake_order_tb.sv */
`timescale 1ns / 1ps

module sort_matrix_snake_order_tb;
  import sms_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 16;   // block back in load state after the last word
  localparam int TAIL_CYCLES   = 64;
  localparam int TOTAL_WORDS   = 270;  // directed part plus random words, at least 270 in all
  localparam int QUIET_AFTER   = 220;  // no idling on either side from here on

  typedef enum int unsigned {MIX_TIES, MIX_EDGES, MIX_FULL} value_mix_e;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     run_last;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  int words_sent = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;

  sort_matrix_snake_order uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .element_value_i (element_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_row_o       (out_row),
    .out_col_o       (out_col),
    .out_value_o     (out_value),
    .run_last_o      (run_last)
  );

  snake_sort_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .element_value_i  (element_value),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_row_i        (out_row),
    .out_col_i        (out_col),
    .out_value_i      (out_value),
    .run_last_i       (run_last),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: drop ready in random bursts, never in quiet mode or with recv_stalls clear.
  always @(negedge clk) begin
    if (quiet || !recv_stalls) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Write one register: setup phase, then access phase, then idle;
  // returns on a falling edge.
  task automatic apb_write(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted word has come out, then let
  // the block settle back into its load state.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Reprogram both dimensions while idle; upper data bits are random noise.
  task automatic set_dims(input logic [DIM_W-1:0] row_raw, input logic [DIM_W-1:0] col_raw);
    logic [31:0] data;
    wait_drained();
    data = $urandom();
    data[DIM_W-1:0] = row_raw;
    apb_write(REG_ROW_COUNT, data);
    data = $urandom();
    data[DIM_W-1:0] = col_raw;
    apb_write(REG_COL_COUNT, data);
  endtask

  // Present one word and hold it until accepted. Valid stays high on return so
  // a back-to-back word just replaces the payload; a gap drops valid first.
  task automatic send_word(input logic signed [DATA_W-1:0] v);
    in_valid      <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    if (!quiet && send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input value_mix_e mix);
    case (mix)
      MIX_TIES:  return int'($urandom_range(0, 7)) - 4;
      MIX_EDGES: begin
        case ($urandom_range(0, 6))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh7FFF_FFFE;
          3:       return 32'sh8000_0001;
          4:       return -1;
          5:       return 0;
          default: return 1;
        endcase
      end
      default:   return $urandom();
    endcase
  endfunction

  // Mostly small dimensions; zero and oversized raw values exercise clamping.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return DIM_W'($urandom_range(DIM_MAX + 1, 15));
      2:       return DIM_W'(DIM_MAX);
      3:       return DIM_W'($urandom_range(5, 7));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Keep sending until a word closes the matrix (results become due).
  task automatic finish_matrix(input value_mix_e mix);
    do send_word(pick_value(mix)); while (pending_count == 0);
  endtask

  initial begin : stimulus
    int phase;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero registers act as 1x1: each word comes straight back, last set.
    set_dims(4'd0, 4'd0);
    send_word(32'sh7FFF_FFFF);
    send_word(32'sh8000_0000);
    send_word(0);
    send_word(-1);

    // 2x3: second row reads right to left; ties and both extremes.
    set_dims(4'd2, 4'd3);
    send_word(-1);
    send_word(32'sh7FFF_FFFF);
    send_word(32'sh8000_0000);
    send_word(0);
    send_word(32'sh8000_0000);
    send_word(1);

    // Shrink mid-load: five of nine words in, then 2x2 lets the next word close
    // the matrix on the first four entries.
    set_dims(4'd3, 4'd3);
    send_word(40);
    send_word(-7);
    send_word(3);
    send_word(12);
    send_word(-100);
    set_dims(4'd2, 4'd2);
    send_word(99);

    // Grow mid-load: one word under 1x2, then 2x2 needs three more.
    set_dims(4'd1, 4'd2);
    send_word(5);
    set_dims(4'd2, 4'd2);
    send_word(-5);
    send_word(32'sh7FFF_FFFF);
    send_word(2);

    // Random phases: new dimensions, one to three full matrices, and now and
    // then a partial load carried across the next register write.
    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      if (phase == 2) set_dims(4'd15, DIM_W'(DIM_MAX));
      else set_dims(pick_dim(), pick_dim());
      quiet = (words_sent >= QUIET_AFTER);
      repeat ($urandom_range(1, 3)) finish_matrix(value_mix_e'($urandom_range(0, 2)));
      if (phase != 2 && $urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 5)) send_word(pick_value(MIX_FULL));
      phase++;
    end

    // Drain everything, then give the block time to show any stray word.
    quiet = 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
